// ----- hdl/multi_stop_gradient_row_color_unit_assert.svh -----
// Assertion macros for the gradient row color unit.
`ifndef MULTI_STOP_GRADIENT_ROW_COLOR_UNIT_ASSERT_SVH
`define MULTI_STOP_GRADIENT_ROW_COLOR_UNIT_ASSERT_SVH

// Checked only while out of reset.
`define MSGRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked during reset as well.
`define MSGRC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- hdl/msgrc_pkg.sv -----
// Shared types and constants of the gradient row color unit.
package msgrc_pkg;

  localparam int MAX_STOPS_DEF = 8;

  localparam int MODE_W  = 2;
  localparam int POS_W   = 17;
  localparam int COLOR_W = 32;
  localparam int ROW_W   = 12;
  localparam int RC_W    = 13;
  localparam int FRAC_W  = 16;
  localparam int IN_W    = 64;
  localparam int OUT_W   = 40;

  localparam logic [POS_W-1:0] POS_ONE  = 17'h10000;
  localparam logic [RC_W-1:0]  RC_RESET = 13'd2;

  localparam int DIV_NUM_W = ROW_W + FRAC_W;
  localparam int DIV_REM_W = POS_W;
  localparam int DIV_CNT_W = 5;
  localparam logic [DIV_CNT_W-1:0] DIV_ITER_P = 5'(DIV_NUM_W);
  localparam logic [DIV_CNT_W-1:0] DIV_ITER_F = 5'(FRAC_W);

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD    = 2'd0,
    MODE_CLEAR  = 2'd1,
    MODE_BASE   = 2'd2,
    MODE_RENDER = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_INS_CHK,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_PHASE,
    ST_DIV_P,
    ST_R_RD,
    ST_R_CHK,
    ST_DIV_F,
    ST_BLEND,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_TARGET,
    WR_SHIFT
  } wr_sel_e;

  typedef enum logic [1:0] {
    RES_HOLD,
    RES_PREV,
    RES_RD
  } res_sel_e;

  typedef struct packed {
    logic     load_item;
    logic     count_clr;
    logic     count_inc;
    logic     idx_inc;
    logic     k_load;
    logic     k_dec;
    logic     rd_idx;
    logic     rd_km1;
    wr_sel_e  wr_sel;
    logic     ok_clr;
    logic     phase_next;
    res_sel_e res_sel;
    logic     prev_load;
    logic     next_load;
    logic     div_start_p;
    logic     div_start_f;
    logic     p_zero;
    logic     p_load;
    logic     f_load;
    logic     blend_step;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  phase;
    logic  pos_bad;
    logic  idx_lt_count;
    logic  idx_zero;
    logic  count_zero;
    logic  count_full;
    logic  k_gt_idx;
    logic  rd_eq;
    logic  rd_gt;
    logic  p_le_rd;
    logic  p_lt_rd;
    logic  rc_small;
    logic  div_busy;
    logic  div_done;
    logic  blend_last;
    logic  out_free;
  } sts_t;

endpackage

// ----- hdl/msgrc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module msgrc_ram #(
  parameter int Width = 49,
  parameter int Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/msgrc_div.sv -----
// Restoring divider, one quotient bit per cycle.
module msgrc_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [msgrc_pkg::DIV_REM_W-1:0]   rem_i,
  input  logic [msgrc_pkg::DIV_NUM_W-1:0]   num_i,
  input  logic [msgrc_pkg::DIV_CNT_W-1:0]   iters_i,
  input  logic [msgrc_pkg::DIV_REM_W-1:0]   den_i,
  output logic                               busy_o,
  output logic                               done_o,
  output logic [msgrc_pkg::DIV_NUM_W-1:0]   quo_o
);
  import msgrc_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_REM_W-1:0] r_q, r_d;
  logic [DIV_NUM_W-1:0] n_q, n_d;
  logic [DIV_NUM_W-1:0] q_q, q_d;
  logic [DIV_REM_W-1:0] d_q, d_d;
  logic [DIV_REM_W:0]   r_sh;
  logic [DIV_REM_W:0]   r_sub;
  logic                 ge;

  assign r_sh  = {r_q, n_q[DIV_NUM_W-1]};
  assign r_sub = r_sh - {1'b0, d_q};
  assign ge    = r_sh >= {1'b0, d_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    r_d    = r_q;
    n_d    = n_q;
    q_d    = q_q;
    d_d    = d_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = iters_i;
      r_d    = rem_i;
      n_d    = num_i;
      q_d    = '0;
      d_d    = den_i;
    end else if (busy_q) begin
      r_d   = ge ? r_sub[DIV_REM_W-1:0] : r_sh[DIV_REM_W-1:0];
      n_d   = {n_q[DIV_NUM_W-2:0], 1'b0};
      q_d   = {q_q[DIV_NUM_W-2:0], ge};
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    r_q   <= r_d;
    n_q   <= n_d;
    q_q   <= q_d;
    d_q   <= d_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = q_q;

endmodule

// ----- hdl/msgrc_ctrl.sv -----
// Sequencer for table updates and row rendering.
module msgrc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_valid_i,
  output logic            s_ready_o,
  input  msgrc_pkg::sts_t sts_i,
  output msgrc_pkg::cmd_t cmd_o
);
  import msgrc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        case (sts_i.mode)
          MODE_ADD:   state_d = sts_i.pos_bad ? ST_OUT : ST_SCAN_RD;
          MODE_CLEAR: state_d = ST_OUT;
          MODE_BASE:  state_d = ST_SCAN_RD;
          default: begin
            if (sts_i.count_zero)    state_d = ST_OUT;
            else if (sts_i.rc_small) state_d = ST_R_RD;
            else                     state_d = ST_DIV_P;
          end
        endcase
      end
      ST_SCAN_RD:  state_d = sts_i.idx_lt_count ? ST_SCAN_CHK : ST_INS_CHK;
      ST_SCAN_CHK: begin
        if (sts_i.rd_eq)      state_d = ST_PHASE;
        else if (sts_i.rd_gt) state_d = ST_INS_CHK;
        else                  state_d = ST_SCAN_RD;
      end
      ST_INS_CHK:  state_d = sts_i.count_full ? ST_PHASE : ST_SHIFT_RD;
      ST_SHIFT_RD: state_d = sts_i.k_gt_idx ? ST_SHIFT_WR : ST_PHASE;
      ST_SHIFT_WR: state_d = ST_SHIFT_RD;
      ST_PHASE: begin
        if (sts_i.mode == MODE_BASE && !sts_i.phase) state_d = ST_SCAN_RD;
        else                                         state_d = ST_OUT;
      end
      ST_DIV_P: begin
        if (sts_i.div_done) state_d = ST_R_RD;
      end
      ST_R_RD: state_d = sts_i.idx_lt_count ? ST_R_CHK : ST_OUT;
      ST_R_CHK: begin
        if (sts_i.idx_zero && sts_i.p_le_rd)      state_d = ST_OUT;
        else if (!sts_i.idx_zero && sts_i.p_lt_rd) state_d = ST_DIV_F;
        else                                       state_d = ST_R_RD;
      end
      ST_DIV_F: begin
        if (sts_i.div_done) state_d = ST_BLEND;
      end
      ST_BLEND: begin
        if (sts_i.blend_last) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o     = '0;
    s_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_ready_o       = 1'b1;
        cmd_o.load_item = s_valid_i;
      end
      ST_DECODE: begin
        case (sts_i.mode)
          MODE_ADD:   cmd_o.ok_clr    = sts_i.pos_bad;
          MODE_CLEAR: cmd_o.count_clr = 1'b1;
          MODE_BASE:  ;
          default: begin
            if (!sts_i.count_zero) begin
              cmd_o.p_zero      = sts_i.rc_small;
              cmd_o.div_start_p = !sts_i.rc_small;
            end
          end
        endcase
      end
      ST_SCAN_RD:  cmd_o.rd_idx = sts_i.idx_lt_count;
      ST_SCAN_CHK: begin
        // replace the color on a match; base color keeps an existing end stop
        if (sts_i.rd_eq) begin
          if (sts_i.mode == MODE_ADD) cmd_o.wr_sel = WR_TARGET;
        end else if (!sts_i.rd_gt) begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      ST_INS_CHK: begin
        cmd_o.ok_clr = sts_i.count_full;
        cmd_o.k_load = !sts_i.count_full;
      end
      ST_SHIFT_RD: begin
        if (sts_i.k_gt_idx) begin
          cmd_o.rd_km1 = 1'b1;
        end else begin
          cmd_o.wr_sel    = WR_TARGET;
          cmd_o.count_inc = 1'b1;
        end
      end
      ST_SHIFT_WR: begin
        cmd_o.wr_sel = WR_SHIFT;
        cmd_o.k_dec  = 1'b1;
      end
      ST_PHASE: begin
        cmd_o.phase_next = sts_i.mode == MODE_BASE && !sts_i.phase;
      end
      ST_DIV_P: cmd_o.p_load = sts_i.div_done;
      ST_R_RD: begin
        if (sts_i.idx_lt_count) cmd_o.rd_idx  = 1'b1;
        else                    cmd_o.res_sel = RES_PREV;
      end
      ST_R_CHK: begin
        if (sts_i.idx_zero && sts_i.p_le_rd) begin
          cmd_o.res_sel = RES_RD;
        end else if (!sts_i.idx_zero && sts_i.p_lt_rd) begin
          cmd_o.next_load   = 1'b1;
          cmd_o.div_start_f = 1'b1;
        end else begin
          cmd_o.prev_load = 1'b1;
          cmd_o.idx_inc   = 1'b1;
        end
      end
      ST_DIV_F: cmd_o.f_load     = sts_i.div_done;
      ST_BLEND: cmd_o.blend_step = 1'b1;
      ST_OUT:   cmd_o.out_load   = sts_i.out_free;
      default:  ;
    endcase
  end

endmodule

// ----- hdl/msgrc_dp.sv -----
// Stop table, divider, blender and result register.
module msgrc_dp #(
  parameter int MAX_STOPS = msgrc_pkg::MAX_STOPS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [msgrc_pkg::RC_W-1:0]     cfg_wdata_i,
  input  logic [msgrc_pkg::IN_W-1:0]     in_data_i,
  input  logic [msgrc_pkg::MODE_W-1:0]   in_user_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [msgrc_pkg::OUT_W-1:0]    out_data_o,
  input  msgrc_pkg::cmd_t                cmd_i,
  output msgrc_pkg::sts_t                sts_o
);
  import msgrc_pkg::*;

  localparam int AW = $clog2(MAX_STOPS);
  localparam int CW = $clog2(MAX_STOPS + 1);
  localparam int EW = POS_W + COLOR_W;

  logic [RC_W-1:0]    row_count_q;
  logic [CW-1:0]      count_q;
  mode_e              mode_q;
  logic [POS_W-1:0]   target_q;
  logic [COLOR_W-1:0] color_q;
  logic [ROW_W-1:0]   row_q;
  logic               phase_q;
  logic               ok_q;
  logic [CW-1:0]      idx_q;
  logic [CW-1:0]      k_q;
  logic [POS_W-1:0]   p_q;
  logic [POS_W-1:0]   prev_pos_q;
  logic [COLOR_W-1:0] prev_color_q;
  logic [COLOR_W-1:0] next_color_q;
  logic [FRAC_W-1:0]  f_q;
  logic [1:0]         bc_q;
  logic [COLOR_W-1:0] result_q;
  logic               out_valid_q;
  logic [OUT_W-1:0]   out_data_q;

  logic [CW-1:0]      km1;
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [EW-1:0]      ram_wdata, ram_rdata;
  logic [POS_W-1:0]   rd_pos;
  logic [COLOR_W-1:0] rd_color;

  logic                 div_start, div_busy, div_done;
  logic [DIV_REM_W-1:0] div_rem, div_den;
  logic [DIV_NUM_W-1:0] div_num, div_quo;
  logic [DIV_CNT_W-1:0] div_iters;
  logic [RC_W-1:0]      rc_m1;

  logic [4:0]         bsel;
  logic [7:0]         s_byte, e_byte;
  logic [POS_W-1:0]   f_ext, f_inv;
  logic [24:0]        mix;

  assign km1      = k_q - CW'(1);
  assign rd_pos   = ram_rdata[POS_W-1:0];
  assign rd_color = ram_rdata[EW-1:POS_W];

  // table port selection
  always_comb begin
    ram_we    = cmd_i.wr_sel != WR_NONE;
    ram_waddr = idx_q[AW-1:0];
    ram_wdata = {color_q, target_q};
    case (cmd_i.wr_sel)
      WR_SHIFT: begin
        ram_waddr = k_q[AW-1:0];
        ram_wdata = ram_rdata;
      end
      default: ;
    endcase
    ram_re    = cmd_i.rd_idx || cmd_i.rd_km1;
    ram_raddr = cmd_i.rd_km1 ? km1[AW-1:0] : idx_q[AW-1:0];
  end

  msgrc_ram #(
    .Width (EW),
    .Depth (MAX_STOPS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // row position, or fraction between two stops
  assign rc_m1     = row_count_q - RC_W'(1);
  assign div_start = cmd_i.div_start_p || cmd_i.div_start_f;
  always_comb begin
    if (cmd_i.div_start_f) begin
      div_rem   = p_q - prev_pos_q;
      div_num   = '0;
      div_iters = DIV_ITER_F;
      div_den   = rd_pos - prev_pos_q;
    end else begin
      div_rem   = '0;
      div_num   = {row_q, {FRAC_W{1'b0}}};
      div_iters = DIV_ITER_P;
      div_den   = {{(DIV_REM_W-RC_W){1'b0}}, rc_m1};
    end
  end

  msgrc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .rem_i   (div_rem),
    .num_i   (div_num),
    .iters_i (div_iters),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // one byte lane per cycle
  assign bsel   = {bc_q, 3'b000};
  assign s_byte = prev_color_q[bsel +: 8];
  assign e_byte = next_color_q[bsel +: 8];
  assign f_ext  = {1'b0, f_q};
  assign f_inv  = POS_ONE - f_ext;
  assign mix    = s_byte * f_inv + e_byte * f_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= RC_RESET;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) row_count_q <= cfg_wdata_i;
      if (cmd_i.count_clr)      count_q <= '0;
      else if (cmd_i.count_inc) count_q <= count_q + CW'(1);
      if (cmd_i.out_load)       out_valid_q <= 1'b1;
      else if (out_ready_i)     out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      mode_q   <= mode_e'(in_user_i);
      target_q <= (mode_e'(in_user_i) == MODE_BASE) ? '0 : in_data_i[POS_W-1:0];
      color_q  <= in_data_i[POS_W +: COLOR_W];
      row_q    <= in_data_i[POS_W+COLOR_W +: ROW_W];
      phase_q  <= 1'b0;
      ok_q     <= 1'b1;
      idx_q    <= '0;
      bc_q     <= '0;
      result_q <= '0;
    end
    if (cmd_i.ok_clr) ok_q <= 1'b0;
    if (cmd_i.phase_next) begin
      phase_q  <= 1'b1;
      target_q <= POS_ONE;
      idx_q    <= '0;
    end
    if (cmd_i.idx_inc) idx_q <= idx_q + CW'(1);
    if (cmd_i.k_load)     k_q <= count_q;
    else if (cmd_i.k_dec) k_q <= km1;
    if (cmd_i.p_zero) p_q <= '0;
    if (cmd_i.p_load) begin
      p_q <= (div_quo > DIV_NUM_W'(POS_ONE)) ? POS_ONE : div_quo[POS_W-1:0];
    end
    if (cmd_i.prev_load) begin
      prev_pos_q   <= rd_pos;
      prev_color_q <= rd_color;
    end
    if (cmd_i.next_load) next_color_q <= rd_color;
    if (cmd_i.f_load)    f_q <= div_quo[FRAC_W-1:0];
    case (cmd_i.res_sel)
      RES_PREV: result_q <= prev_color_q;
      RES_RD:   result_q <= rd_color;
      default:  ;
    endcase
    if (cmd_i.blend_step) begin
      result_q[bsel +: 8] <= mix[23:16];
      bc_q                <= bc_q + 2'd1;
    end
    if (cmd_i.out_load) begin
      out_data_q <= {{(OUT_W-COLOR_W-1){1'b0}}, ok_q, result_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    sts_o.mode         = mode_q;
    sts_o.phase        = phase_q;
    sts_o.pos_bad      = target_q > POS_ONE;
    sts_o.idx_lt_count = idx_q < count_q;
    sts_o.idx_zero     = idx_q == '0;
    sts_o.count_zero   = count_q == '0;
    sts_o.count_full   = count_q >= CW'(MAX_STOPS);
    sts_o.k_gt_idx     = k_q > idx_q;
    sts_o.rd_eq        = rd_pos == target_q;
    sts_o.rd_gt        = rd_pos > target_q;
    sts_o.p_le_rd      = p_q <= rd_pos;
    sts_o.p_lt_rd      = p_q < rd_pos;
    sts_o.rc_small     = row_count_q < RC_RESET;
    sts_o.div_busy     = div_busy;
    sts_o.div_done     = div_done;
    sts_o.blend_last   = bc_q == 2'd3;
    sts_o.out_free     = !out_valid_q || out_ready_i;
  end

endmodule

// ----- hdl/multi_stop_gradient_row_color_unit.sv -----
// Multi-stop gradient row color unit. Keeps a sorted table of up to MAX_STOPS
// color stops and handles one word at a time: add stop, clear, set base color
// and render row, each answered by exactly one result word. Add stop walks the
// table entry by entry through the table RAM's single read port up to the
// insert point, then shifts the entries above it up one at a time; set base
// color places both end stops. Render runs a 28-step bit-serial division for
// the row position unless row_count is below 2, scans the stops, and, if the
// position lies between two stops, runs a 16-step division for the fraction
// and blends one byte lane per cycle. A new word is taken as soon as the
// previous one is handed to the output register, even while that result
// still waits.
`include "multi_stop_gradient_row_color_unit_assert.svh"

module multi_stop_gradient_row_color_unit #(
  parameter int MAX_STOPS = msgrc_pkg::MAX_STOPS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [msgrc_pkg::RC_W-1:0]    cfg_wdata_i,     // row_count
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // stop_position[16:0], stop_color[48:17], row_index[60:49], zero pad
  input  logic [msgrc_pkg::IN_W-1:0]    s_axis_tdata_i,
  input  logic [msgrc_pkg::MODE_W-1:0]  s_axis_tuser_i,  // mode[1:0]
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // row_color[31:0], accepted[32], zero pad
  output logic [msgrc_pkg::OUT_W-1:0]   m_axis_tdata_o
);
  import msgrc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  msgrc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  msgrc_dp #(
    .MAX_STOPS (MAX_STOPS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata_i),
    .in_user_i   (s_axis_tuser_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  `MSGRC_ASSERT(a_busy_after_accept, s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o, "word accepted while still decoding the previous one")
  `MSGRC_ASSERT(a_div_idle_on_start, cmd.div_start_p || cmd.div_start_f |-> !sts.div_busy, "divider restarted while busy")
  `MSGRC_ASSERT(a_no_result_overwrite, cmd.out_load |-> !m_axis_tvalid_o || m_axis_tready_i, "pending result overwritten")
  `MSGRC_ASSERT_RST(a_reset_empty, !rst_ni |=> !m_axis_tvalid_o, "result valid after reset")

endmodule
